@@ hdl/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared constants, request/status codes and controller command type for the
// register pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

  localparam int SLOTS      = 16;
  localparam int CODE_BITS  = 8;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int COUNT_BITS = $clog2(SLOTS + 1);
  localparam int POOLS      = 2;

  // field widths of the request and response channels
  localparam int TYPE_W   = 3;
  localparam int CODE_W   = 8;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int FCOUNT_W = 5;

  // request types
  localparam logic [TYPE_W-1:0] REQ_ALLOC   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_RELEASE = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_RESERVE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_QUERY   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_LOAD    = 3'd4;

  // response status
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POOL_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_CODE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

  typedef logic [SLOTS-1:0]      slot_map_t;
  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [SLOT_BITS-1:0]  slot_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic capture;  // latch the accepted request
    logic commit;   // execute it and load the result register
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/rpa_if.sv @@
// ----------------------------------------------------------------------------
// rpa_req_if / rpa_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpa_req_if;
  import rpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    req_type;
  logic                 pool_sel;
  logic [CODE_W-1:0]    reg_code;
  logic [INDEX_W-1:0]   slot_index;

  modport source (output valid, req_type, pool_sel, reg_code, slot_index, input ready);
  modport sink   (input valid, req_type, pool_sel, reg_code, slot_index, output ready);
endinterface

interface rpa_rsp_if;
  import rpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CODE_W-1:0]    granted_code;
  logic                 is_free;
  logic [STATUS_W-1:0]  status;
  logic [FCOUNT_W-1:0]  free_count;

  modport source (output valid, granted_code, is_free, status, free_count, input ready);
  modport sink   (input valid, granted_code, is_free, status, free_count, output ready);
endinterface

`default_nettype wire

@@ hdl/register_pool_allocator.sv @@
// Flow: an accepted request is latched into the request register, then
// executed into the output register; no new request is accepted before
//   that execution, but the next request is taken while a response waits.
// Reset (synchronous, active high) clears both pools' loaded and free maps
//   and free counts at once; slot codes are not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// register_pool_allocator
// Integer and real register pools with bitmap free lists: load, allocate,
// release, reserve and query by code.
// ----------------------------------------------------------------------------
`default_nettype none

module register_pool_allocator
  import rpa_pkg::*;
(
  input wire        clk,
  input wire        rst,
  rpa_req_if.sink   req,
  rpa_rsp_if.source rsp
);

  cmd_t cmd;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  rpa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req.req_type),
    .pool_sel     (req.pool_sel),
    .reg_code     (req.reg_code),
    .slot_index   (req.slot_index),
    .granted_code (rsp.granted_code),
    .is_free      (rsp.is_free),
    .status       (rsp.status),
    .free_count   (rsp.free_count)
  );

endmodule

`default_nettype wire

@@ hdl/rpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpa_ctrl
// Request sequencer: accept, execute, hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_ctrl
  import rpa_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  wire  rsp_ready,
  output cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  always_comb begin
    req_ready   = (state == ST_IDLE);
    cmd.capture = (state == ST_IDLE) && req_valid;
    // result register free, or being emptied this cycle
    cmd.commit  = (state == ST_EXEC) && (!out_valid || rsp_ready);

    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign rsp_valid = out_valid;

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !req_ready)
    else $error("request accepted while one is executing");

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_EXEC))
    else $error("accepted request not executed");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("committed result not presented");

endmodule

`default_nettype wire

@@ hdl/rpa_datapath.sv @@
// ----------------------------------------------------------------------------
// rpa_datapath
// Pool storage, code compare, priority encoders and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_datapath
  import rpa_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  cmd_t                cmd,
  input  wire [TYPE_W-1:0]    req_type,
  input  wire                 pool_sel,
  input  wire [CODE_W-1:0]    reg_code,
  input  wire [INDEX_W-1:0]   slot_index,
  output logic [CODE_W-1:0]   granted_code,
  output logic                is_free,
  output logic [STATUS_W-1:0] status,
  output logic [FCOUNT_W-1:0] free_count
);

  // latched request
  logic [TYPE_W-1:0]  r_type;
  logic               r_pool;
  code_t              r_code;
  logic [INDEX_W-1:0] r_slot;

  // pool state; codes have no reset, only valid slots are ever read
  code_t     codes [POOLS][SLOTS];
  slot_map_t valid [POOLS];
  slot_map_t free  [POOLS];
  count_t    count [POOLS];

  slot_map_t sel_valid;
  slot_map_t sel_free;
  count_t    sel_count;
  slot_map_t match;
  logic      match_hit;
  slot_idx_t match_idx;
  logic      free_hit;
  slot_idx_t free_idx;
  slot_idx_t load_idx;
  logic      load_ok;

  slot_map_t           free_next;
  count_t              count_next;
  logic [CODE_W-1:0]   grant_next;
  logic                is_free_next;
  logic [STATUS_W-1:0] status_next;
  logic                do_load;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_type <= req_type;
      r_pool <= pool_sel;
      r_code <= reg_code[CODE_BITS-1:0];
      r_slot <= slot_index;
    end
  end

  always_comb begin
    sel_valid = valid[r_pool];
    sel_free  = free[r_pool];
    sel_count = count[r_pool];
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = sel_valid[i] && (codes[r_pool][i] == r_code);
    end
    // highest-numbered hit wins
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) begin
        match_hit = 1'b1;
        match_idx = SLOT_BITS'(i);
      end
      if (sel_free[i]) begin
        free_hit = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
    end
    load_ok  = (int'(r_slot) < SLOTS);
    load_idx = SLOT_BITS'(r_slot);
  end

  always_comb begin
    free_next    = sel_free;
    count_next   = sel_count;
    grant_next   = '0;
    is_free_next = 1'b0;
    status_next  = ST_OK;
    do_load      = 1'b0;
    case (r_type)
      REQ_ALLOC: begin
        if (!free_hit) begin
          status_next = ST_POOL_EMPTY;
        end else begin
          grant_next          = CODE_W'(codes[r_pool][free_idx]);
          free_next[free_idx] = 1'b0;
          count_next          = sel_count - count_t'(1);
        end
      end
      REQ_RELEASE: begin
        if (!match_hit) begin
          status_next = ST_UNKNOWN_CODE;
        end else if (sel_free[match_idx]) begin
          status_next = ST_ALREADY_FREE;
        end else begin
          free_next[match_idx] = 1'b1;
          count_next           = sel_count + count_t'(1);
        end
      end
      REQ_RESERVE: begin
        if (!match_hit) begin
          status_next = ST_UNKNOWN_CODE;
        end else if (sel_free[match_idx]) begin
          free_next[match_idx] = 1'b0;
          count_next           = sel_count - count_t'(1);
        end
      end
      REQ_QUERY: begin
        if (!match_hit) begin
          is_free_next = 1'b1;
          status_next  = ST_UNKNOWN_CODE;
        end else begin
          is_free_next = sel_free[match_idx];
        end
      end
      REQ_LOAD: begin
        if (load_ok) begin
          do_load             = 1'b1;
          free_next[load_idx] = 1'b1;
          if (!sel_free[load_idx]) count_next = sel_count + count_t'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POOLS; p++) begin
        valid[p] <= '0;
        free[p]  <= '0;
        count[p] <= '0;
      end
    end else if (cmd.commit) begin
      free[r_pool]  <= free_next;
      count[r_pool] <= count_next;
      if (do_load) valid[r_pool][load_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_load) codes[r_pool][load_idx] <= r_code;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted_code <= grant_next;
      is_free      <= is_free_next;
      status       <= status_next;
      free_count   <= FCOUNT_W'(count_next);
    end
  end

  a_int_free_in_valid: assert property (@(posedge clk) disable iff (rst)
    (free[0] & ~valid[0]) == '0)
    else $error("integer pool: free slot not loaded");

  a_real_free_in_valid: assert property (@(posedge clk) disable iff (rst)
    (free[1] & ~valid[1]) == '0)
    else $error("real pool: free slot not loaded");

  a_int_count: assert property (@(posedge clk) disable iff (rst)
    int'(count[0]) == $countones(free[0]))
    else $error("integer pool: free count out of step with free map");

  a_real_count: assert property (@(posedge clk) disable iff (rst)
    int'(count[1]) == $countones(free[1]))
    else $error("real pool: free count out of step with free map");

endmodule

`default_nettype wire
